// ----- rtl/pitch_target_generator_macros.svh -----
// Assertion macros used by the pitch target generator checker.
`ifndef PITCH_TARGET_GENERATOR_MACROS_SVH
`define PITCH_TARGET_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PTG_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PTG_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ptg_pkg.sv -----
// Types, codes and the accent rule table of the pitch target generator.
package ptg_pkg;

    localparam logic [2:0] ACC_NONE    = 3'd0;
    localparam logic [2:0] ACC_H_STAR  = 3'd1;
    localparam logic [2:0] ACC_H_OPEN  = 3'd2;
    localparam logic [2:0] ACC_LH      = 3'd3;
    localparam logic [2:0] ACC_LL      = 3'd4;
    localparam logic [2:0] ACC_H_LH    = 3'd5;
    localparam logic [2:0] ACC_H_LL    = 3'd6;
    localparam logic [2:0] ACC_UNKNOWN = 3'd7;

    localparam logic [6:0] INIT_PERCENT  = 7'd0;
    localparam logic [7:0] INIT_FREQ     = 8'd125;
    localparam logic [6:0] FINAL_PERCENT = 7'd99;
    localparam logic [7:0] FINAL_FREQ    = 8'd70;

    typedef enum logic [1:0] {
        ANCHOR_START = 2'd0,
        ANCHOR_PHONE = 2'd1,
        ANCHOR_END   = 2'd2
    } anchor_t;

    typedef struct packed {
        anchor_t    anchor;
        logic [6:0] percent;
        logic [7:0] freq;
    } rule_t;

    typedef struct packed {
        logic [7:0] phone;
        logic [6:0] percent;
        logic [7:0] freq;
    } target_t;

    typedef struct packed {
        logic put;
        logic close;
    } queue_ctrl_t;

    typedef struct packed {
        logic can_put;
        logic can_close;
    } queue_stat_t;

    function automatic logic [2:0] rule_count(input logic [2:0] acc);
        logic [2:0] n;
        case (acc) inside
            ACC_H_STAR:         n = 3'd2;
            ACC_LH, ACC_LL:     n = 3'd1;
            ACC_H_LH, ACC_H_LL: n = 3'd4;
            default:            n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic rule_t rule_at(input logic [2:0] acc, input logic [1:0] j);
        rule_t r;
        r = '{ANCHOR_START, 7'd0, 8'd100};
        case (acc)
            ACC_LH: r = '{ANCHOR_END, 7'd90, 8'd100};
            ACC_LL: r = '{ANCHOR_END, 7'd99, 8'd80};
            default: begin
                case (j)
                    2'd0: r = '{ANCHOR_START, 7'd0, 8'd100};
                    2'd1: r = '{ANCHOR_PHONE, 7'd30, 8'd130};
                    2'd2: r = (acc == ACC_H_LH) ? rule_t'{ANCHOR_PHONE, 7'd80, 8'd100}
                                                : rule_t'{ANCHOR_PHONE, 7'd80, 8'd90};
                    default: r = (acc == ACC_H_LH) ? rule_t'{ANCHOR_END, 7'd99, 8'd120}
                                                   : rule_t'{ANCHOR_END, 7'd99, 8'd80};
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/ptg_accent_ram.sv -----
// Accent code buffer: one write port, one registered read port.
module ptg_accent_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [2:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [2:0]        rdata
);

    logic [2:0] mem [DEPTH];
    logic [2:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ptg_target_queue.sv -----
// One-deep pending target plus output register; tags the final target of a run.
module ptg_target_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ptg_pkg::queue_ctrl_t ctrl,
    input  ptg_pkg::target_t     target,
    output ptg_pkg::queue_stat_t stat,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // target_phone, target_percent, target_freq, 0
    output logic                 m_tlast    // last_of_run
);
    import ptg_pkg::*;

    target_t pend_reg;
    logic    pend_valid_reg;
    target_t out_reg;
    logic    out_last_reg;
    logic    out_valid_reg;
    logic    out_free;

    assign out_free       = !out_valid_reg || m_tready;
    assign stat.can_put   = !pend_valid_reg || out_free;
    assign stat.can_close = !pend_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (ctrl.put && stat.can_put) begin
            pend_reg       <= target;
            pend_valid_reg <= 1'b1;
            if (pend_valid_reg) begin
                out_reg       <= pend_reg;
                out_last_reg  <= 1'b0;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end else if (ctrl.close && pend_valid_reg && out_free) begin
            out_reg        <= pend_reg;
            out_last_reg   <= 1'b1;
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= 1'b0;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.freq, out_reg.percent, out_reg.phone};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/pitch_target_generator.sv -----
// Pitch target generator top level: phoneme sequencer around the accent buffer.
//
// Input stream s_*: one transaction per phoneme, syllable number and accent code
// in s_tdata, end of utterance on s_tlast. Output stream m_*: one transaction per
// pitch target, phoneme index, percent and frequency in m_tdata, m_tlast on the
// final target caused by an input phoneme.
// A phoneme is taken only while the sequencer is idle. Each input passes its accept
// step, a step to buffer its accent and a step to close the run, plus, for each
// buffered phoneme flushed, a read of the accent buffer and an emit step for each
// target (at least one for a phoneme without targets), plus a step for the final
// target at an end of utterance. The single read port and one target per cycle,
// while the output queue can take one, bound this work; the next phoneme waits
// until the run is closed. The first target of a transaction passes the pending
// register before it reaches the output register.
// Reset (aresetn low, synchronous) empties the buffer count, clears the phoneme
// counter and arms the utterance start target; the buffer contents need no clear.
// A stalled receiver holds m_tdata; the sequencer waits with the next target
// pending, and s_tready stays low until the run's last target has reached the
// output register.
module pitch_target_generator #(
    parameter int MAX_SYL_PHONES = 8,
    parameter int MAX_PHONES     = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // syllable_id, accent_code, 0
    input  logic        s_tlast,   // end_of_utterance
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // target_phone, target_percent, target_freq, 0
    output logic        m_tlast    // last_of_run
);
    import ptg_pkg::*;

    localparam int FILL_W = $clog2(MAX_SYL_PHONES + 1);
    localparam int ADDR_W = $clog2(MAX_SYL_PHONES);
    localparam int LIMIT  = (MAX_PHONES - 1 < 255) ? MAX_PHONES - 1 : 255;
    localparam logic [7:0]        PHONE_LIMIT = 8'(LIMIT);
    localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(MAX_SYL_PHONES);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_EMIT  = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_FINAL = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        start_reg, start_next;
    logic [7:0]        prev_reg, prev_next;
    logic [7:0]        counter_reg, counter_next;
    logic              fresh_reg, fresh_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [1:0]        j_reg, j_next;
    logic              phase_new_reg, phase_new_next;
    logic [2:0]        acc_reg, acc_next;
    logic              eou_reg, eou_next;

    queue_ctrl_t q_ctrl;
    queue_stat_t q_stat;
    target_t     put_target;
    logic        ram_we, ram_re;
    logic [2:0]  rd_acc;
    rule_t       rule;
    logic [2:0]  cnt;
    logic [9:0]  p_sum, e_sum;
    logic [7:0]  p_phone, e_phone, rule_phone;
    logic        advance;

    assign s_tready = (state_reg == ST_IDLE);

    assign rule  = rule_at(rd_acc, j_reg);
    assign cnt   = rule_count(rd_acc);
    assign p_sum = {2'b00, start_reg} + 10'(k_reg);
    assign e_sum = {2'b00, start_reg} + 10'(fill_reg) - 10'd1;
    assign p_phone = (p_sum > 10'(PHONE_LIMIT)) ? PHONE_LIMIT : p_sum[7:0];
    assign e_phone = (e_sum > 10'(PHONE_LIMIT)) ? PHONE_LIMIT : e_sum[7:0];

    always_comb begin
        case (rule.anchor)
            ANCHOR_PHONE: rule_phone = p_phone;
            ANCHOR_END:   rule_phone = e_phone;
            default:      rule_phone = start_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        start_next     = start_reg;
        prev_next      = prev_reg;
        counter_next   = counter_reg;
        fresh_next     = fresh_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        phase_new_next = phase_new_reg;
        acc_next       = acc_reg;
        eou_next       = eou_reg;
        q_ctrl         = '0;
        put_target     = '{counter_reg, rule.percent, rule.freq};
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        advance        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    acc_next  = s_tdata[10:8];
                    eou_next  = s_tlast;
                    prev_next = s_tdata[7:0];
                    k_next    = '0;
                    j_next    = '0;
                    phase_new_next = 1'b0;
                    if (fresh_reg) begin
                        fresh_next = 1'b0;
                        fill_next  = '0;
                        start_next = counter_reg;
                        q_ctrl.put = 1'b1;
                        put_target = '{counter_reg, INIT_PERCENT, INIT_FREQ};
                        state_next = ST_WRITE;
                    end else if (s_tdata[7:0] != prev_reg || fill_reg == FILL_FULL) begin
                        if (fill_reg == '0) begin
                            start_next = counter_reg;
                            state_next = ST_WRITE;
                        end else begin
                            state_next = ST_READ;
                        end
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (cnt == 3'd0) begin
                    advance = 1'b1;
                end else if (q_stat.can_put) begin
                    q_ctrl.put = 1'b1;
                    put_target = '{rule_phone, rule.percent, rule.freq};
                    if (3'(j_reg) + 3'd1 == cnt) begin
                        advance = 1'b1;
                    end else begin
                        j_next = j_reg + 2'd1;
                    end
                end
                if (advance) begin
                    j_next = '0;
                    if (FILL_W'(k_reg) + FILL_W'(1) == fill_reg) begin
                        if (phase_new_reg) begin
                            state_next = ST_FINAL;
                        end else begin
                            start_next = counter_reg;
                            fill_next  = '0;
                            state_next = ST_WRITE;
                        end
                    end else begin
                        k_next     = k_reg + ADDR_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_WRITE: begin
                ram_we    = 1'b1;
                fill_next = fill_reg + FILL_W'(1);
                if (eou_reg) begin
                    phase_new_next = 1'b1;
                    k_next         = '0;
                    j_next         = '0;
                    state_next     = ST_READ;
                end else begin
                    if (counter_reg < PHONE_LIMIT) begin
                        counter_next = counter_reg + 8'd1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_FINAL: begin
                if (q_stat.can_put) begin
                    q_ctrl.put = 1'b1;
                    put_target = '{counter_reg, FINAL_PERCENT, FINAL_FREQ};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                q_ctrl.close = 1'b1;
                if (q_stat.can_close) begin
                    state_next = ST_IDLE;
                    if (eou_reg) begin
                        fill_next    = '0;
                        start_next   = '0;
                        prev_next    = '0;
                        counter_next = '0;
                        fresh_next   = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            start_reg   <= '0;
            prev_reg    <= '0;
            counter_reg <= '0;
            fresh_reg   <= 1'b1;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            start_reg   <= start_next;
            prev_reg    <= prev_next;
            counter_reg <= counter_next;
            fresh_reg   <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        j_reg         <= j_next;
        phase_new_reg <= phase_new_next;
        acc_reg       <= acc_next;
        eou_reg       <= eou_next;
    end

    ptg_accent_ram #(
        .DEPTH  (MAX_SYL_PHONES),
        .ADDR_W (ADDR_W)
    ) u_accent_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (acc_reg),
        .re    (ram_re),
        .raddr (k_reg),
        .rdata (rd_acc)
    );

    ptg_target_queue u_target_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (q_ctrl),
        .target   (put_target),
        .stat     (q_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/ptg_checker.sv -----
// Port-level checks of the pitch target generator, bound to the top level.
`include "pitch_target_generator_macros.svh"

module ptg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    logic s_xfer;
    assign s_xfer = s_tvalid && s_tready;

    `PTG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output transaction changed while stalled")
    `PTG_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_xfer, !s_tready, "input taken while a phoneme is still in work")
    `PTG_ASSERT_IMPL(a_run_open, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "input ready before the run's last target")

endmodule

bind pitch_target_generator ptg_checker u_ptg_checker (.*);
